// File: hw/rtl/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mwpo_pkg.sv
// package: widths, register and waveform codes, sine table function
`timescale 1ns / 1ps
`default_nettype none

package mwpo_pkg;

    // parameter defaults
    localparam int PHASE_BITS_DEF     = 32;
    localparam int SINE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF    = 16;

    // fixed field widths
    localparam int AMP_BITS       = 16;
    localparam int STEP_BITS      = 32;
    localparam int WAVE_BITS      = 3;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [STEP_BITS-1:0] STEP_RESET = 32'd19478349;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_WAVEFORM   = 1'b1;

    // waveform codes, the rest play silence
    typedef enum logic [WAVE_BITS-1:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_SAWTOOTH = 3'd2,
        WAVE_TRIANGLE = 3'd3,
        WAVE_SILENCE  = 3'd4
    } wave_t;

    localparam logic [WAVE_BITS-1:0] WAVE_RESET = WAVE_SINE;

    localparam longint unsigned Q30_ONE     = 64'd1 << 30;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // full scale times sin(pi/2 * k / quarter), Q30 series, rounded
    function automatic longint quarter_sine(input longint unsigned k, input int ab,
                                            input int sb);
        longint unsigned fs;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        fs = (64'd1 << (sb - 1)) - 64'd1;
        x  = (HALF_PI_Q30 * k) >> (ab - 2);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 156;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        v  = (s * fs + (Q30_ONE >> 1)) >> 30;
        if (v > fs)
        begin
            v = fs;
        end
        return longint'(v);
    endfunction

    // one sine table entry, built from the quarter wave
    function automatic longint sine_entry(input longint unsigned i, input int ab,
                                          input int sb);
        longint unsigned quarter;
        longint unsigned q;
        longint unsigned r;
        longint unsigned k;
        longint m;
        quarter = 64'd1 << (ab - 2);
        q = i >> (ab - 2);
        r = i & (quarter - 64'd1);
        k = q[0] ? (quarter - r) : r;
        m = quarter_sine(k, ab, sb);
        return q[1] ? -m : m;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/mwpo_front.sv
// front stage: configuration registers, phase accumulator, sine table read
`timescale 1ns / 1ps
`default_nettype none

module mwpo_front #(
    parameter int PHASE_BITS     = mwpo_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = mwpo_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = mwpo_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [mwpo_pkg::CFG_INDEX_BITS-1:0]   wr_index,
    input  wire logic [mwpo_pkg::CFG_DATA_BITS-1:0]    wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [mwpo_pkg::AMP_BITS-1:0]         amplitude,
    input  wire logic                                  next_ready,
    output logic                                       s1_valid,
    output logic [mwpo_pkg::AMP_BITS-1:0]              s1_amp,
    output logic [mwpo_pkg::WAVE_BITS-1:0]             s1_wave,
    output logic [PHASE_BITS-1:0]                      s1_phase,
    output logic signed [SAMPLE_BITS-1:0]              s1_sine
);

    localparam int SINE_SIZE = 1 << SINE_ADDR_BITS;

    logic [mwpo_pkg::STEP_BITS-1:0]  step_reg;
    logic [mwpo_pkg::WAVE_BITS-1:0]  wave_reg;
    logic [PHASE_BITS-1:0]           phase_reg;
    logic [PHASE_BITS-1:0]           phase_next;
    logic                            valid_reg;
    logic [mwpo_pkg::AMP_BITS-1:0]   amp_reg;
    logic [mwpo_pkg::WAVE_BITS-1:0]  item_wave_reg;
    logic [PHASE_BITS-1:0]           item_phase_reg;
    logic signed [SAMPLE_BITS-1:0]   sine_reg;
    logic signed [SAMPLE_BITS-1:0]   sine_rom [SINE_SIZE];
    logic                            ready;
    logic                            accept;

    // sine table contents, fixed at elaboration
    for (genvar gi = 0; gi < SINE_SIZE; gi++)
    begin : g_rom
        assign sine_rom[gi] = SAMPLE_BITS'(mwpo_pkg::sine_entry(gi, SINE_ADDR_BITS,
                                                                SAMPLE_BITS));
    end

    // stage handshake
    assign ready    = !valid_reg || next_ready;
    assign accept   = in_valid && ready;
    assign in_stall = !ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= mwpo_pkg::STEP_RESET;
            wave_reg <= mwpo_pkg::WAVE_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                mwpo_pkg::REG_PHASE_STEP: step_reg <= wr_data[mwpo_pkg::STEP_BITS-1:0];
                mwpo_pkg::REG_WAVEFORM:   wave_reg <= wr_data[mwpo_pkg::WAVE_BITS-1:0];
                default:                  ;
            endcase
        end
    end

    // phase advances once per accepted item and wraps
    assign phase_next = phase_reg + PHASE_BITS'(step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
            end
            if (ready)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    // item payload and registered table read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            amp_reg        <= amplitude;
            item_wave_reg  <= wave_reg;
            item_phase_reg <= phase_reg;
            sine_reg       <= sine_rom[phase_reg[PHASE_BITS-1 -: SINE_ADDR_BITS]];
        end
    end

    assign s1_valid = valid_reg;
    assign s1_amp   = amp_reg;
    assign s1_wave  = item_wave_reg;
    assign s1_phase = item_phase_reg;
    assign s1_sine  = sine_reg;

endmodule

`default_nettype wire

// File: hw/rtl/mwpo_shape.sv
// shape stage: wave magnitude and sign for the selected waveform
`timescale 1ns / 1ps
`default_nettype none

module mwpo_shape #(
    parameter int PHASE_BITS  = mwpo_pkg::PHASE_BITS_DEF,
    parameter int SAMPLE_BITS = mwpo_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s1_valid,
    input  wire logic [mwpo_pkg::AMP_BITS-1:0]         s1_amp,
    input  wire logic [mwpo_pkg::WAVE_BITS-1:0]        s1_wave,
    input  wire logic [PHASE_BITS-1:0]                 s1_phase,
    input  wire logic signed [SAMPLE_BITS-1:0]         s1_sine,
    input  wire logic                                  next_ready,
    output logic                                       ready,
    output logic                                       s2_valid,
    output logic [mwpo_pkg::AMP_BITS-1:0]              s2_amp,
    output logic                                       s2_neg,
    output logic [SAMPLE_BITS-2:0]                     s2_mag
);

    localparam int SHIFT_R = (PHASE_BITS >= SAMPLE_BITS) ? PHASE_BITS - SAMPLE_BITS : 0;
    localparam int SHIFT_L = (PHASE_BITS >= SAMPLE_BITS) ? 0 : SAMPLE_BITS - PHASE_BITS;
    localparam int TRI_W   = 2 * SAMPLE_BITS + 1;
    localparam logic [SAMPLE_BITS-2:0] FULL_SCALE = '1;
    localparam logic [SAMPLE_BITS-1:0] HALF       = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS:0]   WRAP       = {1'b1, {SAMPLE_BITS{1'b0}}};

    logic [SAMPLE_BITS-1:0]          u;
    logic [1:0]                      quad;
    logic [SAMPLE_BITS-1:0]          four_r;
    logic [SAMPLE_BITS:0]            tri_mag;
    logic [TRI_W-1:0]                tri_prod;
    logic [SAMPLE_BITS-1:0]          saw_diff;
    logic [SAMPLE_BITS-1:0]          sine_abs;
    logic                            neg_next;
    logic [SAMPLE_BITS-2:0]          mag_next;
    logic                            valid_reg;
    logic [mwpo_pkg::AMP_BITS-1:0]   amp_reg;
    logic                            neg_reg;
    logic [SAMPLE_BITS-2:0]          mag_reg;

    assign ready = !valid_reg || next_ready;

    // phase scaled to sample width
    assign u      = SAMPLE_BITS'(s1_phase >> SHIFT_R) << SHIFT_L;
    assign quad   = u[SAMPLE_BITS-1 -: 2];
    assign four_r = {u[SAMPLE_BITS-3:0], 2'b00};

    // triangle: magnitude up to full range, then scaled by full scale with rounding
    assign tri_mag  = quad[0] ? (WRAP - {1'b0, four_r}) : {1'b0, four_r};
    assign tri_prod = (TRI_W'(tri_mag) << (SAMPLE_BITS - 1)) - TRI_W'(tri_mag)
                      + TRI_W'(HALF);

    // sawtooth below the midpoint, saturated at negative full scale
    assign saw_diff = HALF - u;

    assign sine_abs = s1_sine[SAMPLE_BITS-1] ? (~s1_sine + 1'b1) : s1_sine;

    // waveform select
    always_comb
    begin
        neg_next = 1'b0;
        mag_next = '0;
        unique case (mwpo_pkg::wave_t'(s1_wave))
            mwpo_pkg::WAVE_SINE:
            begin
                neg_next = s1_sine[SAMPLE_BITS-1];
                mag_next = sine_abs[SAMPLE_BITS-2:0];
            end
            mwpo_pkg::WAVE_SQUARE:
            begin
                neg_next = !((s1_phase != '0) && !s1_phase[PHASE_BITS-1]);
                mag_next = FULL_SCALE;
            end
            mwpo_pkg::WAVE_SAWTOOTH:
            begin
                neg_next = !u[SAMPLE_BITS-1];
                if (u[SAMPLE_BITS-1])
                begin
                    mag_next = u[SAMPLE_BITS-2:0];
                end
                else if (u == '0)
                begin
                    mag_next = FULL_SCALE;
                end
                else
                begin
                    mag_next = saw_diff[SAMPLE_BITS-2:0];
                end
            end
            mwpo_pkg::WAVE_TRIANGLE:
            begin
                neg_next = quad[1];
                mag_next = tri_prod[SAMPLE_BITS +: (SAMPLE_BITS - 1)];
            end
            default:
            begin
                neg_next = 1'b0;
                mag_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            amp_reg <= s1_amp;
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

    assign s2_valid = valid_reg;
    assign s2_amp   = amp_reg;
    assign s2_neg   = neg_reg;
    assign s2_mag   = mag_reg;

endmodule

`default_nettype wire

// File: hw/rtl/mwpo_scale.sv
// scale stage: amplitude multiply with rounding, then signed output register
`timescale 1ns / 1ps
`default_nettype none

module mwpo_scale #(
    parameter int SAMPLE_BITS = mwpo_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s2_valid,
    input  wire logic [mwpo_pkg::AMP_BITS-1:0]         s2_amp,
    input  wire logic                                  s2_neg,
    input  wire logic [SAMPLE_BITS-2:0]                s2_mag,
    output logic                                       ready,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]              sample
);

    localparam int PROD_W = SAMPLE_BITS + mwpo_pkg::AMP_BITS;
    localparam logic [PROD_W-1:0] ROUND = PROD_W'(1) << (mwpo_pkg::AMP_BITS - 1);

    logic [PROD_W-1:0]             prod;
    logic                          mul_valid_reg;
    logic                          mul_neg_reg;
    logic [SAMPLE_BITS-2:0]        mul_mag_reg;
    logic [SAMPLE_BITS-1:0]        mag_ext;
    logic [SAMPLE_BITS-1:0]        sample_next;
    logic                          out_valid_reg;
    logic [SAMPLE_BITS-1:0]        sample_reg;
    logic                          out_ready;

    assign out_ready = !out_valid_reg || !out_stall;
    assign ready     = !mul_valid_reg || out_ready;

    // magnitude times amplitude, rounded to nearest
    assign prod = PROD_W'(s2_mag) * PROD_W'(s2_amp) + ROUND;

    // restore the sign
    assign mag_ext     = {1'b0, mul_mag_reg};
    assign sample_next = mul_neg_reg ? (~mag_ext + 1'b1) : mag_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ready)
            begin
                mul_valid_reg <= s2_valid;
            end
            if (out_ready)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready)
        begin
            mul_neg_reg <= s2_neg;
            mul_mag_reg <= prod[mwpo_pkg::AMP_BITS +: (SAMPLE_BITS - 1)];
        end
        if (out_ready)
        begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

endmodule

`default_nettype wire

// File: hw/rtl/multi_waveform_phase_oscillator.sv
// Phase-accumulator oscillator with sine, square, sawtooth and triangle
// outputs, scaled by a per-item amplitude. Each accepted item produces one
// signed sample; one item is accepted per clock while the input is not
// stalled, and each item passes through the registered sine table read, the
// wave shaping stage, the amplitude multiplier stage and the output register.
// Backpressure on the output fills the pipeline before the input stalls. The
// phase advances by phase_step after every accepted item and wraps; waveform
// codes above triangle give silence.
`timescale 1ns / 1ps
`default_nettype none

module multi_waveform_phase_oscillator #(
    parameter int PHASE_BITS     = mwpo_pkg::PHASE_BITS_DEF,
    parameter int SINE_ADDR_BITS = mwpo_pkg::SINE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS    = mwpo_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [mwpo_pkg::CFG_INDEX_BITS-1:0]   wr_index,
    input  wire logic [mwpo_pkg::CFG_DATA_BITS-1:0]    wr_data,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic [mwpo_pkg::AMP_BITS-1:0]         amplitude,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [SAMPLE_BITS-1:0]              sample
);

    logic                            s1_valid;
    logic [mwpo_pkg::AMP_BITS-1:0]   s1_amp;
    logic [mwpo_pkg::WAVE_BITS-1:0]  s1_wave;
    logic [PHASE_BITS-1:0]           s1_phase;
    logic signed [SAMPLE_BITS-1:0]   s1_sine;
    logic                            s2_ready;
    logic                            s2_valid;
    logic [mwpo_pkg::AMP_BITS-1:0]   s2_amp;
    logic                            s2_neg;
    logic [SAMPLE_BITS-2:0]          s2_mag;
    logic                            s3_ready;

    // phase and table read
    mwpo_front #(
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .amplitude  (amplitude),
        .next_ready (s2_ready),
        .s1_valid   (s1_valid),
        .s1_amp     (s1_amp),
        .s1_wave    (s1_wave),
        .s1_phase   (s1_phase),
        .s1_sine    (s1_sine)
    );

    // waveform shaping
    mwpo_shape #(
        .PHASE_BITS  (PHASE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_shape (
        .clk        (clk),
        .rst_n      (rst_n),
        .s1_valid   (s1_valid),
        .s1_amp     (s1_amp),
        .s1_wave    (s1_wave),
        .s1_phase   (s1_phase),
        .s1_sine    (s1_sine),
        .next_ready (s3_ready),
        .ready      (s2_ready),
        .s2_valid   (s2_valid),
        .s2_amp     (s2_amp),
        .s2_neg     (s2_neg),
        .s2_mag     (s2_mag)
    );

    // amplitude scaling and output
    mwpo_scale #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .s2_valid  (s2_valid),
        .s2_amp    (s2_amp),
        .s2_neg    (s2_neg),
        .s2_mag    (s2_mag),
        .ready     (s3_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

endmodule

`default_nettype wire

// File: hw/rtl/mwpo_checker.sv
// port-level checks for the oscillator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mwpo_checker #(
    parameter int SAMPLE_BITS = mwpo_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic signed [SAMPLE_BITS-1:0] sample
);

    localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // a held result keeps its value
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(sample), "stalled sample changed")

    // samples stay within symmetric full scale
    `ASSERT_IMPL(a_sample_range, clk, rst_n, out_valid, sample != MOST_NEG, "sample outside full scale")

    // the input only stalls when the output is held back
    `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output backpressure")

    // an offered item is only stalled while the output is stalled
    `ASSERT_IMPL(a_stall_source, clk, rst_n, in_valid && in_stall, out_stall, "input stall with output free")

endmodule

bind multi_waveform_phase_oscillator mwpo_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_mwpo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sample    (sample)
);

`default_nettype wire

// File: sim/multi_waveform_phase_oscillator_test.sv
// testbench for the phase oscillator: random amplitudes and settings, samples checked in order
`timescale 1ns / 1ps

import mwpo_pkg::*;

// predicts each sample from the accepted amplitude and holds the ones still due
class sample_checker;
    localparam int PB = PHASE_BITS_DEF;
    localparam int AB = SINE_ADDR_BITS_DEF;
    localparam int SB = SAMPLE_BITS_DEF;
    localparam longint FS = (64'sd1 << (SB - 1)) - 1;

    logic [SB-1:0]        pending_samples[$];
    longint               sine_table[1 << AB];
    bit [PB-1:0]          phase_acc;
    bit [STEP_BITS-1:0]   phase_step;
    bit [WAVE_BITS-1:0]   waveform;
    int                   errors;

    function new();
        build_sine_table();
        phase_acc  = '0;
        phase_step = STEP_RESET;
        waveform   = WAVE_RESET;
        errors     = 0;
    endfunction

    // quarter wave magnitude from the Q30 odd series, rounded to full scale
    function longint unsigned quarter_wave(longint unsigned k);
        longint unsigned divisors[6];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned v;
        divisors = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        x  = (64'd1686629713 * k) >> (AB - 2);
        x2 = (x * x) >> 30;
        t  = 64'd1 << 30;
        foreach (divisors[j])
        begin
            t = (64'd1 << 30) - ((x2 * t) >> 30) / divisors[j];
        end
        s = (x * t) >> 30;
        v = (s * longint'(FS) + (64'd1 << 29)) >> 30;
        if (v > longint'(FS))
        begin
            v = FS;
        end
        return v;
    endfunction

    // full table by quarter-wave symmetry
    function void build_sine_table();
        longint unsigned quarter;
        longint unsigned quad;
        longint unsigned offs;
        longint          mag;
        quarter = 64'd1 << (AB - 2);
        for (int i = 0; i < (1 << AB); i++)
        begin
            quad = i >> (AB - 2);
            offs = i & (quarter - 1);
            mag  = quarter_wave(quad[0] ? quarter - offs : offs);
            sine_table[i] = quad[1] ? -mag : mag;
        end
    endfunction

    // unscaled wave value in [-FS, FS]
    function longint wave_value(bit [PB-1:0] ph, bit [WAVE_BITS-1:0] code);
        longint h;
        longint u;
        longint w;
        longint mag;
        h = 64'sd1 << SB;
        u = longint'(ph >> (PB - SB));
        case (code)
            WAVE_SINE:
            begin
                return sine_table[ph >> (PB - AB)];
            end
            WAVE_SQUARE:
            begin
                return (ph != 0 && ph[PB-1] == 1'b0) ? FS : -FS;
            end
            WAVE_SAWTOOTH:
            begin
                w = u - h / 2;
                return (w < -FS) ? -FS : w;
            end
            WAVE_TRIANGLE:
            begin
                if (u < h / 4)
                begin
                    w = 4 * u;
                end
                else if (u < 3 * (h / 4))
                begin
                    w = 2 * h - 4 * u;
                end
                else
                begin
                    w = 4 * u - 4 * h;
                end
                mag = (w < 0) ? -w : w;
                mag = (mag * FS + h / 2) >> SB;
                return (w < 0) ? -mag : mag;
            end
            default:
            begin
                return 0;
            end
        endcase
    endfunction

    // register write, masked to the register width
    function void note_config(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        if (idx == REG_PHASE_STEP)
        begin
            phase_step = data[STEP_BITS-1:0];
        end
        else if (idx == REG_WAVEFORM)
        begin
            waveform = data[WAVE_BITS-1:0];
        end
    endfunction

    // accepted amplitude: queue its sample, then advance the phase
    function void note_amplitude(logic [AMP_BITS-1:0] amp);
        longint w;
        longint mag;
        longint s;
        w   = wave_value(phase_acc, waveform);
        mag = (w < 0) ? -w : w;
        mag = (mag * longint'(amp) + (64'sd1 << (AMP_BITS - 1))) >> AMP_BITS;
        s   = (w < 0) ? -mag : mag;
        pending_samples.push_back(s[SB-1:0]);
        phase_acc = phase_acc + PB'(phase_step);
    endfunction

    task report_mismatch(string msg);
        $display("%t mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // compare an accepted sample with the oldest prediction
    task check_sample(logic [SB-1:0] got);
        logic [SB-1:0] want;
        if (pending_samples.size() == 0)
        begin
            report_mismatch($sformatf("sample %0d with none due", $signed(got)));
        end
        else
        begin
            want = pending_samples.pop_front();
            if (got !== want)
            begin
                report_mismatch($sformatf("sample got %0d want %0d",
                                          $signed(got), $signed(want)));
            end
        end
    endtask
endclass

module multi_waveform_phase_oscillator_test;
    localparam logic [WAVE_BITS-1:0] WAVE_UNUSED_TOP = 3'd7;
    localparam int BATCH_ITEMS = 70;
    localparam int BATCHES     = 6;
    localparam int HOLD_CYCLES = 60;
    localparam int SETTLE      = 8;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]     wr_index = REG_PHASE_STEP;
    logic [CFG_DATA_BITS-1:0]      wr_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [AMP_BITS-1:0]           amplitude = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic signed [SAMPLE_BITS_DEF-1:0] sample;

    int send_idle = 31;
    int recv_idle = 47;
    bit hold_pending = 1'b0;
    int hold_left = 0;

    sample_checker board = new();

    multi_waveform_phase_oscillator u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .amplitude (amplitude),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample)
    );

    always #10 clk = ~clk;

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_idle);
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            board.check_sample(sample);
        end
    end

    // write both registers on back-to-back cycles
    task automatic write_regs(input logic [CFG_DATA_BITS-1:0] step,
                              input logic [CFG_DATA_BITS-1:0] wave);
        wr_en    <= 1'b1;
        wr_index <= REG_PHASE_STEP;
        wr_data  <= step;
        @(posedge clk);
        board.note_config(REG_PHASE_STEP, step);
        wr_index <= REG_WAVEFORM;
        wr_data  <= wave;
        @(posedge clk);
        board.note_config(REG_WAVEFORM, wave);
        wr_en    <= 1'b0;
    endtask

    // offer one amplitude, with random gaps before it, until accepted
    task automatic send_amp(input logic [AMP_BITS-1:0] a);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        amplitude <= a;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        board.note_amplitude(a);
    endtask

    // drop valid, wait for every due sample, then let the design settle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [AMP_BITS-1:0] random_amp();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
        begin
            return '1;
        end
        else if (pick < 15)
        begin
            return '0;
        end
        return AMP_BITS'($urandom);
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] random_step(int n);
        case (n)
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0001;
            default:
            begin
                case ($urandom_range(3))
                    0: return $urandom_range(32'h0010_0000, 0);
                    1: return 32'h4000_0000 + $urandom_range(255);
                    2: return STEP_RESET;
                    default: return $urandom_range(32'h8000_0000, 0);
                endcase
            end
        endcase
    endfunction

    // random waveform code in the low bits, junk above
    function automatic logic [CFG_DATA_BITS-1:0] random_wave();
        logic [CFG_DATA_BITS-1:0] d;
        d = $urandom;
        if ($urandom_range(9) < 8)
        begin
            d[WAVE_BITS-1:0] = WAVE_BITS'($urandom_range(WAVE_TRIANGLE, WAVE_SINE));
        end
        else
        begin
            d[WAVE_BITS-1:0] = WAVE_BITS'($urandom_range(WAVE_UNUSED_TOP, WAVE_SILENCE));
        end
        return d;
    endfunction

    // run limit
    initial
    begin
        #5_000_000;
        $display("multi_waveform_phase_oscillator_test: done, errors");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [WAVE_BITS-1:0]      codes[6];
        logic [AMP_BITS-1:0]       amps[4];
        logic [CFG_DATA_BITS-1:0]  wdata;
        int n;
        codes = '{WAVE_SINE, WAVE_SQUARE, WAVE_SAWTOOTH, WAVE_TRIANGLE,
                  WAVE_SILENCE, WAVE_UNUSED_TOP};
        amps  = '{16'hFFFF, 16'h8000, 16'h0001, 16'h0000};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: sine at the default step
        send_amp(16'hFFFF);
        send_amp(16'hFFFF);
        drain();

        // quarter-cycle step: phases 1/4, 1/2, 3/4 for every code, phase 0 for all but the first, wrap at the end
        for (int g = 0; g < 6; g++)
        begin
            wdata = $urandom;
            wdata[WAVE_BITS-1:0] = codes[g];
            write_regs(32'h4000_0000 - board.phase_acc, wdata);
            send_amp(16'hFFFF);
            drain();
            write_regs(32'h4000_0000, wdata);
            for (int j = 1; j < 4; j++)
            begin
                send_amp(amps[(j + g) % 4]);
            end
            drain();
        end

        // random batches under three idling patterns
        n = 0;
        for (int mode = 0; mode < 3; mode++)
        begin
            send_idle = (mode == 0) ? 31 : (mode == 1) ? 47 : 0;
            recv_idle = (mode == 0) ? 47 : (mode == 1) ? 31 : 0;
            for (int b = 0; b < BATCHES; b++)
            begin
                write_regs(random_step(n), random_wave());
                if (b == 0 && mode != 1)
                begin
                    hold_pending = 1'b1;
                end
                for (int k = 0; k < BATCH_ITEMS; k++)
                begin
                    send_amp(random_amp());
                end
                drain();
                n++;
            end
        end

        if (board.errors == 0)
        begin
            $display("multi_waveform_phase_oscillator_test: done, clean");
        end
        else
        begin
            $display("multi_waveform_phase_oscillator_test: done, errors");
        end
        $finish;
    end
endmodule
